/* rtl/dft_pkg.sv */
// Package: types and codes for the DNS forward transaction table.
`default_nettype none
package dft_pkg;

    localparam logic [1:0] CMD_FORWARD = 2'd0;
    localparam logic [1:0] CMD_REPLY   = 2'd1;
    localparam logic [1:0] CMD_SWEEP   = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [2:0] KIND_FORWARDED = 3'd0;
    localparam logic [2:0] KIND_RELAY     = 3'd1;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd2;
    localparam logic [2:0] KIND_RESEND    = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd4;
    localparam logic [2:0] KIND_IDLE      = 3'd5;

    localparam logic [31:0] RESEND_MS_RESET = 32'd1500;
    localparam logic [31:0] DROP_MS_RESET   = 32'd4000;

    localparam logic [0:0] REG_RESEND_MS = 1'd0;
    localparam logic [0:0] REG_DROP_MS   = 1'd1;

    // slot record as stored in the table RAM
    typedef struct packed {
        logic [1:0]  tries;
        logic [15:0] our_id;
        logic [15:0] orig_id;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [31:0] sent_ms;
        logic        has_copy;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [15:0] txn_id;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic        copy_kept;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  slot;
        logic [15:0] new_id;
        logic [15:0] orig_id;
        logic [31:0] reply_ip;
        logic [15:0] reply_port;
        logic        reused_oldest;
        logic [31:0] timeouts_total;
        logic [31:0] overflows_total;
        logic        last;
    } out_item_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input item, clear scan state
        logic scan;      // read data for current index is valid, evaluate
        logic commit;    // perform the write decided by the scan
        logic emit;      // register the result item
        logic emit_last; // the emitted result is the last one
        logic idle_res;  // emit the held sweep result, or an idle result
    } dft_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic scan_done; // last index evaluated
        logic sweep_hit; // current sweep slot produces a result
        logic sweep_any; // a sweep result is held
        logic out_full;  // output register occupied and stalled
    } dft_stat_t;

endpackage
`default_nettype wire

/* rtl/dft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module dft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/dft_ctrl.sv */
// Controller state machine: sequences load, scan, commit and result emission.
`default_nettype none
module dft_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic [1:0]       cmd,
    input  wire dft_pkg::dft_stat_t stat,
    output dft_pkg::dft_cmd_t     ctl,
    output logic                  busy
);
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PRIME  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] cmd_reg, cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= dft_pkg::CMD_FORWARD;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ctl        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    ctl.load = 1'b1;
                    cmd_next = cmd;
                    if (cmd == dft_pkg::CMD_UNUSED)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PRIME;
                    end
                end
            end
            ST_PRIME:
            begin
                // first RAM read in flight
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cmd_reg == dft_pkg::CMD_SWEEP)
                begin
                    // a new hit pushes the held result out, so it needs a free output
                    if (!(stat.sweep_hit && stat.sweep_any && stat.out_full))
                    begin
                        ctl.scan = 1'b1;
                        if (stat.sweep_hit && stat.sweep_any)
                        begin
                            ctl.emit = 1'b1;
                        end
                        if (stat.scan_done)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
                else
                begin
                    ctl.scan = 1'b1;
                    if (stat.scan_done)
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT:
            begin
                if (!stat.out_full)
                begin
                    ctl.commit    = 1'b1;
                    ctl.emit      = 1'b1;
                    ctl.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_full)
                begin
                    ctl.idle_res  = 1'b1;
                    ctl.emit      = 1'b1;
                    ctl.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/dft_dp.sv */
// Datapath: slot table, scan logic, counters and output register.
`default_nettype none
module dft_dp #(
    parameter int SLOTS = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dft_pkg::in_item_t     in_item,
    input  wire dft_pkg::dft_cmd_t     ctl,
    input  wire logic [31:0]           resend_ms,
    input  wire logic [31:0]           drop_ms,
    input  wire logic                  out_stall,
    output dft_pkg::dft_stat_t         stat,
    output logic                       out_valid,
    output dft_pkg::out_item_t         out_item
);
    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam int REC_W_L = dft_pkg::REC_W;

    dft_pkg::in_item_t  req_reg;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [IW-1:0]      ridx_reg;   // address being read
    logic [IW-1:0]      cidx_reg;   // index whose data is at rdata
    logic               found_reg;  // free slot / id match found
    logic [IW-1:0]      hit_reg;
    logic [IW-1:0]      old_reg;    // oldest slot so far
    logic [31:0]        old_ms_reg;
    dft_pkg::slot_rec_t hrec_reg;   // record of matched slot
    logic               any_reg;    // pend_reg holds a sweep result
    dft_pkg::out_item_t pend_reg;   // sweep result held until the next one is known
    logic [15:0]        ntx_reg;
    logic [31:0]        tcnt_reg, ocnt_reg;
    logic               ovalid_reg;
    dft_pkg::out_item_t oitem_reg;

    dft_pkg::slot_rec_t rrec, wrec;
    logic [REC_W_L-1:0] rdata;
    logic               we;
    logic [IW-1:0]      waddr;
    logic [IW-1:0]      raddr;

    // hold the read on the current index while the scan waits
    assign raddr = ctl.scan ? ridx_reg : cidx_reg;

    dft_ram #(.WIDTH(REC_W_L), .DEPTH(SLOTS)) u_tab (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
        .raddr(raddr), .rdata(rdata)
    );
    assign rrec = dft_pkg::slot_rec_t'(rdata);

    logic        cur_used;
    logic [31:0] age;
    logic        is_sweep;
    logic        do_retry, do_drop, hit;
    logic        scan_done;
    logic        out_free;

    assign cur_used  = used_reg[cidx_reg];
    assign is_sweep  = req_reg.cmd == dft_pkg::CMD_SWEEP;
    assign age       = req_reg.now_ms - rrec.sent_ms;
    assign do_retry  = cur_used && rrec.tries == 2'd1 && age > resend_ms;
    assign do_drop   = cur_used && !do_retry && rrec.tries >= 2'd2 && age > drop_ms;
    assign hit       = is_sweep && (do_drop || (do_retry && rrec.has_copy));
    assign scan_done = cidx_reg == LAST_IDX;
    assign out_free  = !ovalid_reg || !out_stall;

    assign stat.scan_done = scan_done;
    assign stat.sweep_hit = hit;
    assign stat.sweep_any = any_reg;
    assign stat.out_full  = !out_free;

    // table write port
    always_comb
    begin
        we    = 1'b0;
        waddr = cidx_reg;
        wrec  = rrec;
        if (ctl.scan && is_sweep && do_retry)
        begin
            we         = 1'b1;
            wrec.tries = 2'd2;
        end
        if (ctl.commit && req_reg.cmd == dft_pkg::CMD_FORWARD)
        begin
            we               = 1'b1;
            waddr            = found_reg ? hit_reg : old_reg;
            wrec.tries       = 2'd1;
            wrec.our_id      = ntx_reg;
            wrec.orig_id     = req_reg.txn_id;
            wrec.client_ip   = req_reg.client_ip;
            wrec.client_port = req_reg.client_port;
            wrec.sent_ms     = req_reg.now_ms;
            wrec.has_copy    = req_reg.copy_kept;
        end
    end

    logic [IW-1:0]      fw_slot;
    logic [15:0]        ntx_inc;
    logic [31:0]        tcnt_next, ocnt_next;
    dft_pkg::out_item_t res;
    dft_pkg::out_item_t emit_item;

    assign fw_slot = found_reg ? hit_reg : old_reg;
    assign ntx_inc = ntx_reg + 16'd1;

    always_comb
    begin
        used_next = used_reg;
        tcnt_next = tcnt_reg;
        ocnt_next = ocnt_reg;
        res       = '0;
        res.last  = ctl.emit_last;
        if (ctl.idle_res)
        begin
            res.kind = dft_pkg::KIND_IDLE;
        end
        else if (ctl.scan && is_sweep)
        begin
            if (do_drop)
            begin
                used_next[cidx_reg] = 1'b0;
                tcnt_next           = tcnt_reg + 32'd1;
                res.kind            = dft_pkg::KIND_TIMEOUT;
            end
            else
            begin
                res.kind   = dft_pkg::KIND_RESEND;
                res.new_id = rrec.our_id;
            end
            res.slot = 6'(cidx_reg);
        end
        else if (ctl.commit)
        begin
            if (req_reg.cmd == dft_pkg::CMD_FORWARD)
            begin
                used_next[fw_slot] = 1'b1;
                if (!found_reg)
                begin
                    ocnt_next = ocnt_reg + 32'd1;
                end
                res.kind          = dft_pkg::KIND_FORWARDED;
                res.slot          = 6'(fw_slot);
                res.new_id        = ntx_reg;
                res.orig_id       = req_reg.txn_id;
                res.reused_oldest = !found_reg;
            end
            else if (found_reg)
            begin
                used_next[hit_reg] = 1'b0;
                res.kind           = dft_pkg::KIND_RELAY;
                res.slot           = 6'(hit_reg);
                res.orig_id        = hrec_reg.orig_id;
                res.reply_ip       = hrec_reg.client_ip;
                res.reply_port     = hrec_reg.client_port;
            end
            else
            begin
                res.kind = dft_pkg::KIND_UNKNOWN;
            end
        end
        res.timeouts_total  = tcnt_next;
        res.overflows_total = ocnt_next;
    end

    // a sweep sends out its held result when the next hit arrives, the last one at finish
    always_comb
    begin
        emit_item = res;
        if (ctl.scan)
        begin
            emit_item = pend_reg;
        end
        else if (ctl.idle_res && any_reg)
        begin
            emit_item      = pend_reg;
            emit_item.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            ntx_reg    <= 16'd1;
            tcnt_reg   <= '0;
            ocnt_reg   <= '0;
            ovalid_reg <= 1'b0;
            ridx_reg   <= '0;
            cidx_reg   <= '0;
            found_reg  <= 1'b0;
            hit_reg    <= '0;
            any_reg    <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            tcnt_reg <= tcnt_next;
            ocnt_reg <= ocnt_next;
            if (ctl.commit && req_reg.cmd == dft_pkg::CMD_FORWARD)
            begin
                ntx_reg <= (ntx_inc == 16'd0) ? 16'd1 : ntx_inc;
            end
            if (ctl.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            if (ctl.load)
            begin
                ridx_reg  <= '0;
                cidx_reg  <= '0;
                found_reg <= 1'b0;
                any_reg   <= 1'b0;
            end
            else if (ctl.scan)
            begin
                cidx_reg <= ridx_reg;
                if (ridx_reg != LAST_IDX)
                begin
                    ridx_reg <= ridx_reg + IW'(1);
                end
                if (hit)
                begin
                    any_reg <= 1'b1;
                end
                if (!found_reg)
                begin
                    if (req_reg.cmd == dft_pkg::CMD_FORWARD && !cur_used)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= cidx_reg;
                    end
                    else if (req_reg.cmd == dft_pkg::CMD_REPLY && cur_used &&
                             rrec.our_id == req_reg.txn_id)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= cidx_reg;
                    end
                end
            end
            else
            begin
                // PRIME: issue next read so that cidx trails ridx by one
                if (ridx_reg == '0 && cidx_reg == '0 && !ctl.commit && !ctl.emit)
                begin
                    ridx_reg <= (SLOTS > 1) ? IW'(1) : '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= in_item;
        end
        if (ctl.scan)
        begin
            if (!found_reg && cur_used && rrec.our_id == req_reg.txn_id)
            begin
                hrec_reg <= rrec;
            end
            if (cidx_reg == '0 ||
                rrec.sent_ms - old_ms_reg >= 32'h8000_0000)
            begin
                old_reg    <= cidx_reg;
                old_ms_reg <= rrec.sent_ms;
            end
            if (hit)
            begin
                pend_reg <= res;
            end
        end
        if (ctl.emit)
        begin
            oitem_reg <= emit_item;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;
endmodule
`default_nettype wire

/* rtl/dns_forward_transaction_table.sv */
// Top level: DNS forward transaction table with APB configuration.
// Flow: an accepted item is primed, then scanned one slot per cycle (a sweep scan waits
// while a new result cannot leave), then committed or finished; output stalls delay it.
// An unused cmd skips prime and scan. No new item is taken until the last result is emitted.
// Reset: async active low; clears valid bits, counters, next id to one, and the
// resend/drop registers to 1500/4000 ms. Table RAM contents are not cleared.
`default_nettype none
module dns_forward_transaction_table #(
    parameter int SLOTS = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire dft_pkg::in_item_t   in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output dft_pkg::out_item_t       out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    logic [31:0] resend_ms_reg, drop_ms_reg;
    logic        busy, in_fire;
    dft_pkg::dft_cmd_t  ctl;
    dft_pkg::dft_stat_t stat;

    assign pready   = 1'b1;
    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resend_ms_reg <= dft_pkg::RESEND_MS_RESET;
            drop_ms_reg   <= dft_pkg::DROP_MS_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == dft_pkg::REG_RESEND_MS)
            begin
                resend_ms_reg <= pwdata;
            end
            else
            begin
                drop_ms_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == dft_pkg::REG_DROP_MS) ? drop_ms_reg : resend_ms_reg;

    dft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .cmd(in_item.cmd),
        .stat(stat), .ctl(ctl), .busy(busy)
    );

    dft_dp #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .ctl(ctl),
        .resend_ms(resend_ms_reg), .drop_ms(drop_ms_reg), .out_stall(out_stall),
        .stat(stat), .out_valid(out_valid), .out_item(out_item)
    );
endmodule
`default_nettype wire

/* rtl/dft_checker.sv */
// Port-level checker for the transaction table, bound to the top level.
`default_nettype none
module dft_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire dft_pkg::out_item_t out_item
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.kind <= dft_pkg::KIND_IDLE)
        else $error("bad result kind");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind == dft_pkg::KIND_FORWARDED ||
        out_item.kind == dft_pkg::KIND_RELAY || out_item.kind == dft_pkg::KIND_UNKNOWN)
        |-> out_item.last)
        else $error("single result without last");

    a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken at once");
endmodule

bind dns_forward_transaction_table dft_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire
